// ----- rtl/auger_stepper_feed_sequencer_unit_defines.svh -----
// assertion macros of the feed sequencer checker
`ifndef AUGER_STEPPER_FEED_SEQUENCER_UNIT_DEFINES_SVH
`define AUGER_STEPPER_FEED_SEQUENCER_UNIT_DEFINES_SVH

// consequent must hold on the same edge as the antecedent
`define ASFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold on the edge after the antecedent
`define ASFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/asfs_pkg.sv -----
// shared types and constants of the auger stepper feed sequencer
package asfs_pkg;

    // microsteps per eighth of a revolution
    localparam int unsigned STEPS_PER_EIGHTH = 200;

    // field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned QTY_W   = 8;
    localparam int unsigned EIGHT_W = 8;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned UNITS_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EIGHTHS_PER_UNIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EIGHTHS_PER_BACKUP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP_TICKS    = 2'd2;

    // configuration reset values
    localparam int unsigned EPU_RESET = 8;
    localparam int unsigned EPB_RESET = 1;
    localparam int unsigned HST_RESET = 156;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 2'd0,
        CMD_FEED_OFF  = 2'd1,
        CMD_FEED_HOLD = 2'd2,
        CMD_END       = 2'd3
    } t_command;

    // one configuration write beat
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // one result beat
    typedef struct packed {
        logic step_out;
        logic dir_out;
        logic motor_enable;
        logic busy_res;
        logic unit_done;
        logic rejected;
    } t_result;

endpackage

// ----- rtl/asfs_if.sv -----
// handshake channels of the feed sequencer: input, configuration and result
interface asfs_in_if import asfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [QTY_W-1:0] quantity;

    modport source (output valid, output command, output quantity, input ready);
    modport sink   (input valid, input command, input quantity, output ready);
endinterface

interface asfs_cfg_if import asfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface asfs_out_if import asfs_pkg::*; ();
    logic valid;
    logic ready;
    logic step_out;
    logic dir_out;
    logic motor_enable;
    logic busy_res;
    logic unit_done;
    logic rejected;

    modport source (output valid, output step_out, output dir_out, output motor_enable,
                    output busy_res, output unit_done, output rejected, input ready);
    modport sink   (input valid, input step_out, input dir_out, input motor_enable,
                    input busy_res, input unit_done, input rejected, output ready);
endinterface

// ----- rtl/auger_stepper_feed_sequencer_unit.sv -----
// Auger stepper feed sequencer. Each input beat is one microsecond tick or a command
// (feed then disable, feed and hold enabled, end). A beat is taken every cycle while the
// input is ready: the sequencer state advances in one register stage and the beat's
// result lands in a two-entry result queue, offered in the cycle after the beat is
// accepted; the input stays ready while fewer than two results wait downstream and with
// two waiting stalls until the receiver takes one. Configuration writes are always ready
// and apply to beats accepted after the write edge; step counts are taken when each move
// starts and the half-step length is read live on every tick.
module auger_stepper_feed_sequencer_unit import asfs_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    asfs_in_if.sink     i_feed,
    asfs_cfg_if.sink    i_cfg,
    asfs_out_if.source  o_res
);

    t_cfg_wr cfg_wr;
    t_result result;
    logic    in_accept;
    logic    out_take;

    t_result    r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_result    head;

    // handshakes
    assign i_cfg.ready   = 1'b1;
    assign i_feed.ready  = (r_count != 2'd2);
    assign in_accept     = i_feed.valid && i_feed.ready;
    assign out_take      = o_res.valid && o_res.ready;

    assign cfg_wr.we    = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    asfs_seq_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_wr),
        .i_accept   (in_accept),
        .i_command  (i_feed.command),
        .i_quantity (i_feed.quantity),
        .o_result   (result)
    );

    // result queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (in_accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({in_accept, out_take})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_queue[r_wr_ptr] <= result;
        end
    end

    // output beat
    assign head               = r_queue[r_rd_ptr];
    assign o_res.valid        = (r_count != 2'd0);
    assign o_res.step_out     = head.step_out;
    assign o_res.dir_out      = head.dir_out;
    assign o_res.motor_enable = head.motor_enable;
    assign o_res.busy_res     = head.busy_res;
    assign o_res.unit_done    = head.unit_done;
    assign o_res.rejected     = head.rejected;

endmodule

// ----- rtl/asfs_seq_core.sv -----
// step sequencer state, configuration registers and per-beat next-state logic
module asfs_seq_core import asfs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg_wr          i_cfg,
    input  logic             i_accept,
    input  logic [CMD_W-1:0] i_command,
    input  logic [QTY_W-1:0] i_quantity,
    output t_result          o_result
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BACK = 2'd1,
        PH_JIG  = 2'd2,
        PH_FEED = 2'd3
    } t_phase;

    // move positions, one past the feed move means the unit is finished
    localparam logic [2:0] MV_BACK = 3'd1;
    localparam logic [2:0] MV_JIG  = 3'd2;
    localparam logic [2:0] MV_FEED = 3'd3;

    typedef struct packed {
        t_phase              phase;
        logic [STEP_W-1:0]   steps;
        logic [UNITS_W-1:0]  units;
        logic                done;
    } t_move;

    // find the next move with a nonzero step count, retiring units on the way
    function automatic t_move f_enter(input logic [2:0]         p,
                                      input logic [UNITS_W-1:0] units,
                                      input logic [STEP_W-1:0]  bsteps,
                                      input logic [STEP_W-1:0]  fsteps);
        t_move              m;
        logic               nb;
        logic               nf;
        logic               wrap;
        logic [UNITS_W-1:0] u1;
        nb      = |bsteps;
        nf      = |fsteps;
        wrap    = 1'b0;
        u1      = units - UNITS_W'(1);
        m.phase = PH_IDLE;
        m.steps = '0;
        m.units = units;
        m.done  = 1'b0;
        case (p)
            MV_BACK, MV_JIG: begin
                if (nb) begin
                    m.phase = (p == MV_BACK) ? PH_BACK : PH_JIG;
                    m.steps = bsteps;
                end else if (nf) begin
                    m.phase = PH_FEED;
                    m.steps = fsteps;
                end else begin
                    m.done  = 1'b1;
                    m.units = '0;
                end
            end
            MV_FEED: begin
                if (nf) begin
                    m.phase = PH_FEED;
                    m.steps = fsteps;
                end else begin
                    wrap = 1'b1;
                end
            end
            default: wrap = 1'b1;
        endcase
        // unit finished: start the next one or go idle
        if (wrap) begin
            m.done  = 1'b1;
            m.units = u1;
            if (u1 != '0) begin
                if (nb) begin
                    m.phase = PH_BACK;
                    m.steps = bsteps;
                end else if (nf) begin
                    m.phase = PH_FEED;
                    m.steps = fsteps;
                end else begin
                    m.units = '0;
                end
            end
        end
        return m;
    endfunction

    // configuration, kept as step counts and a clamped half-step length
    logic [STEP_W-1:0] r_unit_steps;
    logic [STEP_W-1:0] r_backup_steps;
    logic [TICK_W-1:0] r_half_ticks;

    // sequence state
    t_phase             r_phase,       n_phase;
    logic [UNITS_W-1:0] r_units_left,  n_units_left;
    logic [STEP_W-1:0]  r_steps_left,  n_steps_left;
    logic [TICK_W-1:0]  r_tick_count,  n_tick_count;
    logic               r_step_level,  n_step_level;
    logic               r_hold_enable, n_hold_enable;
    logic               r_enable_level, n_enable_level;

    logic              busy;
    logic              do_tick;
    logic              cmd_load;
    logic              half_end;
    logic              tick_enter;
    logic [TICK_W-1:0] tick_inc;
    logic [STEP_W-1:0] step_dec;
    logic [2:0]        enter_p;
    logic [UNITS_W-1:0] enter_units;
    t_move             mv;
    logic              unit_done;
    logic              rejected;

    // decode the beat and the tick path
    always_comb begin
        busy        = (r_phase != PH_IDLE);
        tick_inc    = r_tick_count + TICK_W'(1);
        half_end    = (tick_inc >= r_half_ticks);
        step_dec    = r_steps_left - STEP_W'(1);
        do_tick     = i_accept && ((i_command == CMD_TICK) || busy);
        cmd_load    = i_accept && !busy && (i_quantity != '0)
                      && ((i_command == CMD_FEED_OFF) || (i_command == CMD_FEED_HOLD));
        tick_enter  = do_tick && busy && half_end && !r_step_level && (step_dec == '0);
        enter_p     = cmd_load ? MV_BACK : (3'({1'b0, r_phase}) + 3'd1);
        enter_units = cmd_load ? i_quantity : r_units_left;
        mv          = f_enter(enter_p, enter_units, r_backup_steps, r_unit_steps);
    end

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_units_left   = r_units_left;
        n_steps_left   = r_steps_left;
        n_tick_count   = r_tick_count;
        n_step_level   = r_step_level;
        n_hold_enable  = r_hold_enable;
        n_enable_level = r_enable_level;
        rejected       = 1'b0;

        if (i_command != CMD_TICK && busy) begin
            rejected = 1'b1;
        end else if (i_command == CMD_FEED_OFF || i_command == CMD_FEED_HOLD) begin
            n_hold_enable  = (i_command == CMD_FEED_HOLD);
            n_enable_level = (i_command == CMD_FEED_HOLD) || (i_quantity != '0);
        end else if (i_command == CMD_END) begin
            n_hold_enable  = 1'b0;
            n_enable_level = 1'b0;
        end

        // half-step timing
        if (do_tick && busy) begin
            if (!half_end) begin
                n_tick_count = tick_inc;
            end else begin
                n_tick_count = '0;
                if (r_step_level) begin
                    n_step_level = 1'b0;
                end else begin
                    n_steps_left = step_dec;
                    n_step_level = (step_dec != '0);
                end
            end
        end

        // move entry after a load or at the end of a move
        if (cmd_load || tick_enter) begin
            n_phase      = mv.phase;
            n_units_left = mv.units;
            n_steps_left = mv.steps;
            n_tick_count = '0;
            n_step_level = (mv.phase != PH_IDLE);
            if (mv.phase == PH_IDLE && !n_hold_enable) begin
                n_enable_level = 1'b0;
            end
        end

        unit_done = (cmd_load || tick_enter) && mv.done;
    end

    // result of this beat
    always_comb begin
        o_result.step_out     = n_step_level;
        o_result.dir_out      = (n_phase == PH_BACK);
        o_result.motor_enable = n_enable_level;
        o_result.busy_res     = (n_phase != PH_IDLE);
        o_result.unit_done    = unit_done;
        o_result.rejected     = i_accept && rejected;
    end

    // configuration and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_steps   <= STEP_W'(EPU_RESET * STEPS_PER_EIGHTH);
            r_backup_steps <= STEP_W'(EPB_RESET * STEPS_PER_EIGHTH);
            r_half_ticks   <= TICK_W'(HST_RESET);
            r_phase        <= PH_IDLE;
            r_units_left   <= '0;
            r_steps_left   <= '0;
            r_tick_count   <= '0;
            r_step_level   <= 1'b0;
            r_hold_enable  <= 1'b0;
            r_enable_level <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    REG_EIGHTHS_PER_UNIT: begin
                        r_unit_steps <= STEP_W'(i_cfg.data[EIGHT_W-1:0]
                                                * STEP_W'(STEPS_PER_EIGHTH));
                    end
                    REG_EIGHTHS_PER_BACKUP: begin
                        r_backup_steps <= STEP_W'(i_cfg.data[EIGHT_W-1:0]
                                                  * STEP_W'(STEPS_PER_EIGHTH));
                    end
                    REG_HALF_STEP_TICKS: begin
                        // zero acts as one tick
                        r_half_ticks <= (i_cfg.data[TICK_W-1:0] == '0) ? TICK_W'(1)
                                                                       : i_cfg.data[TICK_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_phase        <= n_phase;
                r_units_left   <= n_units_left;
                r_steps_left   <= n_steps_left;
                r_tick_count   <= n_tick_count;
                r_step_level   <= n_step_level;
                r_hold_enable  <= n_hold_enable;
                r_enable_level <= n_enable_level;
            end
        end
    end

endmodule

// ----- rtl/asfs_checker.sv -----
// port-level checks of the feed sequencer and their bind
`include "auger_stepper_feed_sequencer_unit_defines.svh"

module asfs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_step_out,
    input logic i_dir_out,
    input logic i_motor_enable,
    input logic i_busy_res
);

    // an accepted beat always has a result waiting on the next edge
    `ASFS_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "accepted beat left no result")

    // step pulses and backward direction only during a running sequence
    `ASFS_ASSERT_SAME(a_motion_needs_busy, i_clk, i_rst_n, i_out_valid && (i_step_out || i_dir_out), i_busy_res, "motion shown while idle")

    // a running sequence keeps the coils energized
    `ASFS_ASSERT_SAME(a_busy_needs_enable, i_clk, i_rst_n, i_out_valid && i_busy_res, i_motor_enable, "sequence running with motor disabled")

    // a stalled result beat stays offered
    `ASFS_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat withdrawn while stalled")

endmodule

bind auger_stepper_feed_sequencer_unit asfs_checker u_asfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_feed.valid),
    .i_in_ready     (i_feed.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_step_out     (o_res.step_out),
    .i_dir_out      (o_res.dir_out),
    .i_motor_enable (o_res.motor_enable),
    .i_busy_res     (o_res.busy_res)
);

// ----- tb/sv/auger_stepper_feed_sequencer_unit_tb.sv -----
// self-checking testbench of the auger stepper feed sequencer with its own level predictor
module auger_stepper_feed_sequencer_unit_tb;
    import asfs_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned REPORT_MAX  = 10;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_BACK = 2'd1,
        SEQ_JIG  = 2'd2,
        SEQ_FEED = 2'd3
    } t_seq_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    asfs_in_if  feed_if ();
    asfs_cfg_if cfg_if ();
    asfs_out_if res_if ();

    auger_stepper_feed_sequencer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_feed  (feed_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // predicted sequencer state and register copies
    logic [EIGHT_W-1:0] epu_reg;
    logic [EIGHT_W-1:0] epb_reg;
    logic [TICK_W-1:0]  hst_reg;
    logic [UNITS_W-1:0] units_left;
    t_seq_phase         seq_phase;
    logic [STEP_W-1:0]  steps_left;
    logic [TICK_W-1:0]  tick_count;
    logic               step_level;
    logic               hold_enable;
    logic               enable_level;
    logic               unit_done_flag;

    // expected output levels, oldest first
    t_result     pending_levels[$];
    int unsigned mismatch_count;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned quiet_cycles;
    bit          gaps_on;
    int          stall_left;
    int          hold_left;

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // load the next nonzero move starting at phase p, wrapping into further units
    function automatic void start_move(input int unsigned p);
        int unsigned move = p;
        logic [STEP_W-1:0] n;
        while (1'b1) begin
            if (move > 3) begin
                unit_done_flag = 1'b1;
                units_left = units_left - 1'b1;
                if (units_left == '0) begin
                    seq_phase  = SEQ_IDLE;
                    steps_left = '0;
                    tick_count = '0;
                    step_level = 1'b0;
                    if (!hold_enable) enable_level = 1'b0;
                    return;
                end
                move = 1;
            end
            n = STEP_W'((move == 3 ? epu_reg : epb_reg) * STEPS_PER_EIGHTH);
            if (n != '0) begin
                seq_phase  = t_seq_phase'(move[1:0]);
                steps_left = n;
                tick_count = '0;
                step_level = 1'b1;
                return;
            end
            move++;
        end
    endfunction

    // one microsecond of pulse timing
    function automatic void advance_tick();
        logic [TICK_W-1:0] half = (hst_reg == '0) ? TICK_W'(1) : hst_reg;
        if (seq_phase == SEQ_IDLE) return;
        tick_count = tick_count + 1'b1;
        if (tick_count < half) return;
        tick_count = '0;
        if (step_level) begin
            step_level = 1'b0;
            return;
        end
        steps_left = steps_left - 1'b1;
        if (steps_left != '0) step_level = 1'b1;
        else start_move(int'(seq_phase) + 1);
    endfunction

    // apply one input beat to the predicted state and return the expected levels
    function automatic t_result sequencer_next(input t_command cmd,
                                               input logic [QTY_W-1:0] qty);
        t_result lv;
        logic    rej;
        rej = 1'b0;
        unit_done_flag = 1'b0;
        if (cmd != CMD_TICK && seq_phase != SEQ_IDLE) begin
            rej = 1'b1;
            advance_tick();
        end else if (cmd == CMD_FEED_OFF || cmd == CMD_FEED_HOLD) begin
            hold_enable  = (cmd == CMD_FEED_HOLD);
            enable_level = 1'b1;
            if (qty == '0) begin
                if (!hold_enable) enable_level = 1'b0;
            end else begin
                units_left = qty;
                start_move(1);
            end
        end else if (cmd == CMD_END) begin
            hold_enable  = 1'b0;
            enable_level = 1'b0;
        end else begin
            advance_tick();
        end
        lv.step_out     = step_level;
        lv.dir_out      = (seq_phase == SEQ_BACK);
        lv.motor_enable = enable_level;
        lv.busy_res     = (seq_phase != SEQ_IDLE);
        lv.unit_done    = unit_done_flag;
        lv.rejected     = rej;
        return lv;
    endfunction

    // result receiver: long hold first, then per-beat stall
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else if (stall_left != 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // result checker, levels shown as step/dir/en/busy/done/rej
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.step_out     = res_if.step_out;
            got.dir_out      = res_if.dir_out;
            got.motor_enable = res_if.motor_enable;
            got.busy_res     = res_if.busy_res;
            got.unit_done    = res_if.unit_done;
            got.rejected     = res_if.rejected;
            stall_left = gaps_on ? int'($urandom_range(0, 3)) : 0;
            if (pending_levels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("beat %0d arrived with nothing expected: got %b",
                             results_seen, got);
            end else begin
                want = pending_levels.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("beat %0d: expected %b, got %b",
                                 results_seen, want, got);
                end
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((feed_if.valid && feed_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    // offer one input beat after a random gap and predict its levels
    task automatic send_beat(input t_command cmd, input logic [QTY_W-1:0] qty);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            feed_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        feed_if.valid    <= 1'b1;
        feed_if.command  <= cmd;
        feed_if.quantity <= qty;
        @(posedge i_clk);
        while (!feed_if.ready) @(posedge i_clk);
        pending_levels.push_back(sequencer_next(cmd, qty));
        beats_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_EIGHTHS_PER_UNIT:   epu_reg = val[EIGHT_W-1:0];
            REG_EIGHTHS_PER_BACKUP: epb_reg = val[EIGHT_W-1:0];
            REG_HALF_STEP_TICKS:    hst_reg = val[TICK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic configure(input int unsigned epu, input int unsigned epb,
                             input int unsigned hst);
        write_reg(REG_EIGHTHS_PER_UNIT, CFG_DATA_W'(epu));
        write_reg(REG_EIGHTHS_PER_BACKUP, CFG_DATA_W'(epb));
        write_reg(REG_HALF_STEP_TICKS, CFG_DATA_W'(hst));
    endtask

    // stop offering, wait for every expected beat, then let the pipe empty
    task automatic settle();
        @(negedge i_clk);
        feed_if.valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // tick until the running feed ends, then settle
    task automatic drain_to_idle();
        while (seq_phase != SEQ_IDLE) send_beat(CMD_TICK, QTY_W'($urandom));
        settle();
    endtask

    // reset registers: commands that start no sequence
    task automatic check_idle_commands();
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_END, 8'hff);
        send_beat(CMD_FEED_OFF, 8'h00);
        send_beat(CMD_FEED_HOLD, 8'h00);
        send_beat(CMD_TICK, 8'hff);
        send_beat(CMD_END, 8'h00);
        send_beat(CMD_TICK, 8'h5a);
        settle();
    endtask

    // all moves empty: every unit completes on the command beat
    task automatic check_zero_length_units();
        configure(0, 0, 0);
        send_beat(CMD_FEED_OFF, 8'hff);
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_FEED_HOLD, 8'haa);
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_END, 8'h00);
        send_beat(CMD_FEED_OFF, 8'h55);
        send_beat(CMD_FEED_HOLD, 8'h00);
        send_beat(CMD_END, 8'h00);
        settle();
        write_reg(REG_HALF_STEP_TICKS, 16'hffff);
        send_beat(CMD_FEED_OFF, 8'h01);
        send_beat(CMD_TICK, 8'h00);
        settle();
    endtask

    // one unit of backup and jiggle moves with an empty feed move and zero
    // half-step length, commands rejected while busy
    task automatic check_single_unit_and_rejects();
        configure(0, 1, 0);
        send_beat(CMD_FEED_HOLD, 8'h01);
        repeat (5) send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_FEED_OFF, 8'h03);
        send_beat(CMD_FEED_HOLD, 8'h01);
        send_beat(CMD_END, 8'h00);
        repeat (500) send_beat(CMD_TICK, QTY_W'($urandom));
        send_beat(CMD_END, 8'h00);
        drain_to_idle();
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_END, 8'h00);
        settle();
    endtask

    // register extremes with commands that start no sequence
    task automatic check_extremes();
        configure(255, 255, 65535);
        send_beat(CMD_FEED_OFF, 8'h00);
        send_beat(CMD_FEED_HOLD, 8'h00);
        send_beat(CMD_END, 8'h00);
        settle();
    endtask

    // receiver holds off while ticks keep coming, then the sender pauses
    task automatic check_backpressure();
        configure(1, 0, 1);
        gaps_on = 1'b0;
        send_beat(CMD_FEED_OFF, 8'h01);
        hold_left = 64;
        repeat (120) send_beat(CMD_TICK, QTY_W'($urandom));
        settle();
        gaps_on = 1'b1;
        repeat (40) send_beat(CMD_TICK, QTY_W'($urandom));
        drain_to_idle();
    endtask

    // random settings, each followed by random feeds and ticks
    task automatic run_random_feeds(input int unsigned target);
        int unsigned first;
        int unsigned span;
        int unsigned pick;
        bit          empty_units;
        t_command    cmd;
        logic [QTY_W-1:0] qty;
        first = beats_sent;
        while (beats_sent - first < target) begin
            empty_units = ($urandom_range(0, 3) == 0);
            if (empty_units) configure(0, 0, $urandom_range(0, 3));
            else configure(1, 0, $urandom_range(0, 1));
            gaps_on = ($urandom_range(0, 4) != 0);
            span = $urandom_range(100, 250);
            repeat (span) begin
                qty = QTY_W'($urandom);
                if (seq_phase == SEQ_IDLE) begin
                    pick = $urandom_range(0, 9);
                    if (pick <= 5) begin
                        cmd = ($urandom_range(0, 1) == 0) ? CMD_FEED_OFF : CMD_FEED_HOLD;
                        if (!empty_units) qty = ($urandom_range(0, 3) == 0) ?
                                                QTY_W'($urandom_range(0, 2)) : 8'h01;
                    end else if (pick == 6) begin
                        cmd = CMD_END;
                    end else begin
                        cmd = CMD_TICK;
                    end
                end else if ($urandom_range(0, 39) == 0) begin
                    cmd = t_command'($urandom_range(1, 3));
                end else begin
                    cmd = CMD_TICK;
                end
                send_beat(cmd, qty);
            end
            drain_to_idle();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        feed_if.valid    = 1'b0;
        feed_if.command  = '0;
        feed_if.quantity = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        res_if.ready     = 1'b0;
        epu_reg          = EIGHT_W'(EPU_RESET);
        epb_reg          = EIGHT_W'(EPB_RESET);
        hst_reg          = TICK_W'(HST_RESET);
        units_left       = '0;
        seq_phase        = SEQ_IDLE;
        steps_left       = '0;
        tick_count       = '0;
        step_level       = 1'b0;
        hold_enable      = 1'b0;
        enable_level     = 1'b0;
        unit_done_flag   = 1'b0;
        mismatch_count   = 0;
        beats_sent       = 0;
        results_seen     = 0;
        quiet_cycles     = 0;
        stall_left       = 0;
        hold_left        = 0;
        gaps_on          = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_idle_commands();
        check_zero_length_units();
        check_single_unit_and_rejects();
        check_extremes();
        check_backpressure();
        run_random_feeds(450);

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
